FILE: design/rles_pkg.sv
// shared types, constants and helper functions for the rgb led effect sequencer
package rles_pkg;

    localparam int TIMER_BITS  = 16;
    localparam int PERIOD_BITS = 16;
    localparam int COLOR_BITS  = 24;
    localparam int CHAN_BITS   = 8;
    localparam int MODE_BITS   = 2;

    // breath level is kept as a step count, level = count * BREATH_STEP
    localparam int BREATH_STEP = 5;
    localparam int BREATH_FULL = 100;
    localparam int LEVEL_TOP   = BREATH_FULL / BREATH_STEP;
    localparam int LEVEL_BITS  = $clog2(LEVEL_TOP + 1);

    // count * 2^RECIP_SHIFT / LEVEL_TOP, rounded up
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int SCALE_BITS  = CHAN_BITS + RECIP_BITS;

    localparam int APB_DATA_BITS  = 32;
    localparam int REG_INDEX_BITS = 3;
    localparam int APB_ADDR_BITS  = REG_INDEX_BITS + 2;

    localparam logic [MODE_BITS-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_STEADY = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_BLINK  = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_BREATH = 2'd3;

    localparam logic [REG_INDEX_BITS-1:0] REG_EFFECT_MODE  = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_COLOR_A      = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_COLOR_B      = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_STEADY       = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_BLINK_HALF   = 3'd4;
    localparam logic [REG_INDEX_BITS-1:0] REG_BREATH_STEP  = 3'd5;

    localparam logic [PERIOD_BITS-1:0] BLINK_HALF_RESET  = 16'd100;
    localparam logic [PERIOD_BITS-1:0] BREATH_STEP_RESET = 16'd50;

    typedef struct packed {
        logic [MODE_BITS-1:0]   effect_mode;
        logic [COLOR_BITS-1:0]  color_a_rgb;
        logic [COLOR_BITS-1:0]  color_b_rgb;
        logic [COLOR_BITS-1:0]  steady_rgb;
        logic [PERIOD_BITS-1:0] blink_half_period_ms;
        logic [PERIOD_BITS-1:0] breath_step_ms;
    } rles_cfg_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } rles_rgb_t;

    function automatic logic [RECIP_BITS-1:0] breath_recip(input logic [LEVEL_BITS-1:0] count);
        logic [RECIP_BITS-1:0] r;
        unique case (count)
            5'd0:    r = 17'd0;
            5'd1:    r = 17'd3277;
            5'd2:    r = 17'd6554;
            5'd3:    r = 17'd9831;
            5'd4:    r = 17'd13108;
            5'd5:    r = 17'd16384;
            5'd6:    r = 17'd19661;
            5'd7:    r = 17'd22938;
            5'd8:    r = 17'd26215;
            5'd9:    r = 17'd29492;
            5'd10:   r = 17'd32768;
            5'd11:   r = 17'd36045;
            5'd12:   r = 17'd39322;
            5'd13:   r = 17'd42599;
            5'd14:   r = 17'd45876;
            5'd15:   r = 17'd49152;
            5'd16:   r = 17'd52429;
            5'd17:   r = 17'd55706;
            5'd18:   r = 17'd58983;
            5'd19:   r = 17'd62260;
            5'd20:   r = 17'd65536;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // chan * level / 100, truncated, by one multiply with a rounded-up reciprocal
    function automatic logic [CHAN_BITS-1:0] scale_chan(input logic [CHAN_BITS-1:0] chan,
                                                        input logic [LEVEL_BITS-1:0] count);
        logic [SCALE_BITS-1:0] prod;
        prod = SCALE_BITS'(chan) * SCALE_BITS'(breath_recip(count));
        return prod[RECIP_SHIFT +: CHAN_BITS];
    endfunction

endpackage

FILE: design/rles_if.sv
// stream interfaces for tick beats and colour beats
interface rles_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface rles_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

FILE: design/rgb_led_effect_sequencer_top.sv
// top level of the rgb led effect sequencer
//
//   port      dir  kind          payload
//   tick      in   valid/ready   restart
//   led       out  valid/ready   red_out, green_out, blue_out
//   apb       in   apb write/rd  six effect registers at 4*index
//
// one tick beat per cycle while the engine advances; a tick goes from the input register,
// then through engine logic into the result register
// the state update and colour of a tick are settled in one pass through rles_engine
// reset clears the effect state (steady output armed) and both valid flags;
// registers return to their reset values
// a stall on led holds the result register; tick keeps flowing while a tick
// that makes no colour, or a free result register, lets the engine advance
module rgb_led_effect_sequencer_top
    import rles_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    rles_tick_if.sink                tick,
    rles_rgb_if.source               led,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    rles_cfg_t cfg;

    // input register
    logic      in_valid_reg, in_valid_next;
    logic      restart_reg;
    logic      in_take;

    // result register
    logic      out_valid_reg, out_valid_next;
    rles_rgb_t rgb_reg;

    // engine handshake
    logic      emit;
    rles_rgb_t rgb_calc;
    logic      fire;
    logic      out_free;

    rles_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rles_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (restart_reg),
        .advance (fire),
        .emit    (emit),
        .rgb     (rgb_calc)
    );

    // result register can take a colour when empty or drained this cycle
    assign out_free = !out_valid_reg || led.ready;
    // a tick without a colour never waits on the output side
    assign fire     = in_valid_reg && (!emit || out_free);
    assign in_take  = tick.valid && tick.ready;

    assign tick.ready = !in_valid_reg || fire;

    assign in_valid_next  = in_take || (in_valid_reg && !fire);
    assign out_valid_next = (fire && emit) || (out_valid_reg && !led.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            restart_reg <= tick.restart;
        end
        if (fire && emit)
        begin
            rgb_reg <= rgb_calc;
        end
    end

    assign led.valid     = out_valid_reg;
    assign led.red_out   = rgb_reg.red;
    assign led.green_out = rgb_reg.green;
    assign led.blue_out  = rgb_reg.blue;

endmodule

FILE: design/rles_cfg.sv
// apb register bank for the effect settings
module rles_cfg
    import rles_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready,
    output rles_cfg_t                 cfg
);

    rles_cfg_t                 cfg_reg;
    logic                      wr_en;
    logic [REG_INDEX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.effect_mode          <= MODE_OFF;
            cfg_reg.color_a_rgb          <= '0;
            cfg_reg.color_b_rgb          <= '0;
            cfg_reg.steady_rgb           <= '0;
            cfg_reg.blink_half_period_ms <= BLINK_HALF_RESET;
            cfg_reg.breath_step_ms       <= BREATH_STEP_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_EFFECT_MODE: cfg_reg.effect_mode          <= pwdata[MODE_BITS-1:0];
                REG_COLOR_A:     cfg_reg.color_a_rgb          <= pwdata[COLOR_BITS-1:0];
                REG_COLOR_B:     cfg_reg.color_b_rgb          <= pwdata[COLOR_BITS-1:0];
                REG_STEADY:      cfg_reg.steady_rgb           <= pwdata[COLOR_BITS-1:0];
                REG_BLINK_HALF:  cfg_reg.blink_half_period_ms <= pwdata[PERIOD_BITS-1:0];
                REG_BREATH_STEP: cfg_reg.breath_step_ms       <= pwdata[PERIOD_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_EFFECT_MODE: prdata = APB_DATA_BITS'(cfg_reg.effect_mode);
            REG_COLOR_A:     prdata = APB_DATA_BITS'(cfg_reg.color_a_rgb);
            REG_COLOR_B:     prdata = APB_DATA_BITS'(cfg_reg.color_b_rgb);
            REG_STEADY:      prdata = APB_DATA_BITS'(cfg_reg.steady_rgb);
            REG_BLINK_HALF:  prdata = APB_DATA_BITS'(cfg_reg.blink_half_period_ms);
            REG_BREATH_STEP: prdata = APB_DATA_BITS'(cfg_reg.breath_step_ms);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: design/rles_engine.sv
// effect state and per-tick next-state and colour logic
module rles_engine
    import rles_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rles_cfg_t cfg,
    input  logic      restart,
    input  logic      advance,
    output logic      emit,
    output rles_rgb_t rgb
);

    localparam int CMP_W = ((TIMER_BITS > PERIOD_BITS) ? TIMER_BITS : PERIOD_BITS) + 1;

    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic                  second_reg, second_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic                  falling_reg, falling_next;
    logic                  pending_reg, pending_next;

    // state after restart is applied
    logic [TIMER_BITS-1:0] timer_cur;
    logic                  second_cur;
    logic [LEVEL_BITS-1:0] level_cur;
    logic                  falling_cur;
    logic                  pending_cur;

    logic [PERIOD_BITS-1:0] period_sel;
    logic [CMP_W-1:0]       period_eff;
    logic [CMP_W-1:0]       period_lim;
    logic [CMP_W-1:0]       timer_inc;
    logic                   wrap;
    logic [LEVEL_BITS-1:0]  level_step;

    assign timer_cur   = restart ? '0 : timer_reg;
    assign second_cur  = restart ? 1'b0 : second_reg;
    assign level_cur   = restart ? '0 : level_reg;
    assign falling_cur = restart ? 1'b0 : falling_reg;
    assign pending_cur = restart ? 1'b1 : pending_reg;

    // timer wrap against the selected period, zero acts as one
    always_comb
    begin
        period_sel = (cfg.effect_mode == MODE_BLINK) ? cfg.blink_half_period_ms
                                                     : cfg.breath_step_ms;
        period_lim = {{(CMP_W-1){1'b0}}, 1'b1} << TIMER_BITS;
        period_eff = (period_sel == '0) ? {{(CMP_W-1){1'b0}}, 1'b1} : CMP_W'(period_sel);
        if (period_eff > period_lim)
        begin
            period_eff = period_lim;
        end
        timer_inc = CMP_W'(timer_cur) + {{(CMP_W-1){1'b0}}, 1'b1};
        wrap      = (timer_inc >= period_eff);
    end

    // breath level walk, turning at both ends
    always_comb
    begin
        if (!falling_cur)
        begin
            level_step = level_cur + 1'b1;
        end
        else
        begin
            level_step = (level_cur != '0) ? level_cur - 1'b1 : '0;
        end
        if (level_step > LEVEL_BITS'(LEVEL_TOP))
        begin
            level_step = LEVEL_BITS'(LEVEL_TOP);
        end
    end

    always_comb
    begin
        timer_next   = timer_cur;
        second_next  = second_cur;
        level_next   = level_cur;
        falling_next = falling_cur;
        pending_next = pending_cur;
        emit         = 1'b0;
        rgb          = cfg.steady_rgb;
        unique case (cfg.effect_mode)
            MODE_OFF:
            begin
            end
            MODE_STEADY:
            begin
                if (pending_cur)
                begin
                    emit         = 1'b1;
                    pending_next = 1'b0;
                end
            end
            MODE_BLINK:
            begin
                emit = (timer_cur == '0);
                rgb  = second_cur ? cfg.color_b_rgb : cfg.color_a_rgb;
                timer_next = wrap ? '0 : timer_inc[TIMER_BITS-1:0];
                if (wrap)
                begin
                    second_next = ~second_cur;
                end
            end
            MODE_BREATH:
            begin
                if (timer_cur == '0)
                begin
                    emit       = 1'b1;
                    level_next = level_step;
                    if (level_step == LEVEL_BITS'(LEVEL_TOP) || level_step == '0)
                    begin
                        falling_next = ~falling_cur;
                    end
                end
                rgb.red    = scale_chan(cfg.color_a_rgb[23:16], level_step);
                rgb.green  = scale_chan(cfg.color_a_rgb[15:8], level_step);
                rgb.blue   = scale_chan(cfg.color_a_rgb[7:0], level_step);
                timer_next = wrap ? '0 : timer_inc[TIMER_BITS-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg   <= '0;
            second_reg  <= 1'b0;
            level_reg   <= '0;
            falling_reg <= 1'b0;
            pending_reg <= 1'b1;
        end
        else if (advance)
        begin
            timer_reg   <= timer_next;
            second_reg  <= second_next;
            level_reg   <= level_next;
            falling_reg <= falling_next;
            pending_reg <= pending_next;
        end
    end

endmodule

FILE: design/rles_checker.sv
// port-level checks for the rgb led effect sequencer, bound to the top level
module rles_checker
    import rles_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [7:0]               red_out,
    input logic [7:0]               green_out,
    input logic [7:0]               blue_out,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic [APB_ADDR_BITS-1:0] paddr,
    input logic [APB_DATA_BITS-1:0] pwdata,
    input logic [APB_DATA_BITS-1:0] prdata
);

    // a stalled colour beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("colour beat dropped while stalled");

    // a stalled colour beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red_out) && $stable(green_out) && $stable(blue_out))
        else $error("colour payload changed while stalled");

    // a new colour beat follows a tick beat that was taken into the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("colour beat without a tick beat");

    // mode register reads back what was written
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr == '0 ##1 paddr == '0
        |-> prdata[MODE_BITS-1:0] == $past(pwdata[MODE_BITS-1:0]))
        else $error("mode register readback mismatch");

endmodule

bind rgb_led_effect_sequencer_top rles_checker u_rles_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (led.valid),
    .out_ready (led.ready),
    .red_out   (led.red_out),
    .green_out (led.green_out),
    .blue_out  (led.blue_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

FILE: dv/rles_effect_checker.sv
// scoreboard for the rgb led effect sequencer: follows the register writes and predicts each led beat
module rles_effect_checker
    import rles_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    rles_tick_if                     tick,
    rles_rgb_if                      led,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic                     pready,
    output int                       fail_count,
    output int                       pending
);

    rles_cfg_t             cfg;
    logic [TIMER_BITS-1:0] phase_timer;
    logic                  showing_b;
    int                    breath_pct;
    logic                  breath_down;
    logic                  steady_armed;
    rles_rgb_t             awaited_colors[$];
    rles_rgb_t             want_color;
    int                    errors;

    // periods never exceed the timer range, so only zero needs care
    function automatic logic step_phase(input logic [PERIOD_BITS-1:0] period);
        int span;
        span = (period == '0) ? 1 : int'(period);
        if (int'(phase_timer) + 1 >= span)
        begin
            phase_timer = '0;
            return 1'b1;
        end
        phase_timer = phase_timer + 1'b1;
        return 1'b0;
    endfunction

    function automatic logic next_led_color(input logic restart, output rles_rgb_t color);
        logic      fired;
        rles_rgb_t base;
        fired = 1'b0;
        color = '0;
        if (restart)
        begin
            phase_timer  = '0;
            showing_b    = 1'b0;
            breath_pct   = 0;
            breath_down  = 1'b0;
            steady_armed = 1'b1;
        end
        case (cfg.effect_mode)
            MODE_STEADY:
            begin
                if (steady_armed)
                begin
                    steady_armed = 1'b0;
                    color        = cfg.steady_rgb;
                    fired        = 1'b1;
                end
            end
            MODE_BLINK:
            begin
                if (phase_timer == '0)
                begin
                    color = showing_b ? cfg.color_b_rgb : cfg.color_a_rgb;
                    fired = 1'b1;
                end
                if (step_phase(cfg.blink_half_period_ms))
                    showing_b = !showing_b;
            end
            MODE_BREATH:
            begin
                if (phase_timer == '0)
                begin
                    if (!breath_down)
                        breath_pct = breath_pct + BREATH_STEP;
                    else
                        breath_pct = (breath_pct >= BREATH_STEP) ? breath_pct - BREATH_STEP : 0;
                    if (breath_pct > BREATH_FULL)
                        breath_pct = BREATH_FULL;
                    // turn around at full and at dark
                    if (breath_pct == BREATH_FULL || breath_pct == 0)
                        breath_down = !breath_down;
                    base        = cfg.color_a_rgb;
                    color.red   = CHAN_BITS'((int'(base.red) * breath_pct) / BREATH_FULL);
                    color.green = CHAN_BITS'((int'(base.green) * breath_pct) / BREATH_FULL);
                    color.blue  = CHAN_BITS'((int'(base.blue) * breath_pct) / BREATH_FULL);
                    fired       = 1'b1;
                end
                void'(step_phase(cfg.breath_step_ms));
            end
            default:
            begin
            end
        endcase
        return fired;
    endfunction

    task automatic check_chan(input string field, input logic [CHAN_BITS-1:0] want,
                              input logic [CHAN_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.effect_mode          = MODE_OFF;
            cfg.color_a_rgb          = '0;
            cfg.color_b_rgb          = '0;
            cfg.steady_rgb           = '0;
            cfg.blink_half_period_ms = BLINK_HALF_RESET;
            cfg.breath_step_ms       = BREATH_STEP_RESET;
            phase_timer              = '0;
            showing_b                = 1'b0;
            breath_pct               = 0;
            breath_down              = 1'b0;
            steady_armed             = 1'b1;
            awaited_colors.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_BITS-1:2])
                    REG_EFFECT_MODE: cfg.effect_mode          = pwdata[MODE_BITS-1:0];
                    REG_COLOR_A:     cfg.color_a_rgb          = pwdata[COLOR_BITS-1:0];
                    REG_COLOR_B:     cfg.color_b_rgb          = pwdata[COLOR_BITS-1:0];
                    REG_STEADY:      cfg.steady_rgb           = pwdata[COLOR_BITS-1:0];
                    REG_BLINK_HALF:  cfg.blink_half_period_ms = pwdata[PERIOD_BITS-1:0];
                    REG_BREATH_STEP: cfg.breath_step_ms       = pwdata[PERIOD_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (tick.valid && tick.ready)
            begin
                if (next_led_color(tick.restart, want_color))
                    awaited_colors.push_back(want_color);
            end
            if (led.valid && led.ready)
            begin
                if (awaited_colors.size() == 0)
                begin
                    $error("led beat with no color expected: red %0d green %0d blue %0d",
                           led.red_out, led.green_out, led.blue_out);
                    errors++;
                end
                else
                begin
                    want_color = awaited_colors.pop_front();
                    check_chan("red_out", want_color.red, led.red_out);
                    check_chan("green_out", want_color.green, led.green_out);
                    check_chan("blue_out", want_color.blue, led.blue_out);
                end
            end
            pending <= awaited_colors.size();
        end
        fail_count <= errors;
    end

endmodule

FILE: dv/testbench.sv
// top of the rgb led effect sequencer testbench: clock, reset, tick and register stimulus, verdict
module testbench;
    import rles_pkg::*;

    // cycles with no beat on any port before the run is declared hung
    localparam int WATCHDOG_LIMIT  = 3000;
    // long receiver hold-off that backs the block up onto its tick port
    localparam int HOLD_OFF_CYCLES = 400;
    // random ticks to send after the directed part
    localparam int RANDOM_TICKS    = 1550;
    // margin for a tick to pass the input register and reach the color register
    localparam int SETTLE_CYCLES   = 6;
    // addresses past the last register, writes there must change nothing
    localparam logic [REG_INDEX_BITS-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [REG_INDEX_BITS-1:0] SPARE_INDEX_HI = 3'd7;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    rles_tick_if tick_ch ();
    rles_rgb_if  led_ch ();

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int ticks_sent  = 0;
    bit hold_req    = 1'b0;   // raised by stimulus, consumed by the led receiver
    bit tx_calm     = 1'b0;   // sender offers back to back while set

    // periods last written, used to size the tick count of a phase
    logic [PERIOD_BITS-1:0] cur_half = BLINK_HALF_RESET;
    logic [PERIOD_BITS-1:0] cur_step = BREATH_STEP_RESET;

    rgb_led_effect_sequencer_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_ch),
        .led     (led_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rles_effect_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick_ch),
        .led        (led_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // idle run length: mostly short, now and then a long stretch
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // period register value: mostly short so colors come often, with zero and the top
    function automatic logic [PERIOD_BITS-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 70)
            return PERIOD_BITS'($urandom_range(1, 4));
        else if (r < 92)
            return PERIOD_BITS'($urandom_range(5, 40));
        else if (r < 98)
            return PERIOD_BITS'($urandom_range(41, 300));
        return PERIOD_BITS'($urandom_range(0, 65535));
    endfunction

    // setup cycle, then access cycle; the register takes the value at the access edge
    task automatic apb_write(input logic [REG_INDEX_BITS-1:0] idx,
                             input logic [APB_DATA_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // offer one tick beat after a random gap and wait until it is taken
    task automatic send_tick(input logic restart);
        int gap;
        gap = (tx_calm || $urandom_range(0, 99) < 65) ? 0 : idle_len();
        if (gap > 0)
        begin
            tick_ch.valid   <= 1'b0;
            tick_ch.restart <= 1'($urandom);   // noise while nothing is offered
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= restart;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
    endtask

    // stop offering, let every expected color arrive, then let ticks with no color drain
    task automatic quiesce();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // new random effect setting; sometimes only the mode changes so state carries over
    task automatic shuffle_effect(output int n_ticks, output bit keep_state);
        logic [MODE_BITS-1:0] mode;
        int                   r;
        r    = $urandom_range(0, 99);
        mode = (r < 10) ? MODE_OFF : (r < 28) ? MODE_STEADY : (r < 64) ? MODE_BLINK : MODE_BREATH;
        keep_state = ($urandom_range(0, 3) == 0);
        if (!keep_state)
        begin
            cur_half = pick_period();
            cur_step = pick_period();
            // upper pwdata bits are random, the block must drop them
            apb_write(REG_COLOR_A, $urandom);
            apb_write(REG_COLOR_B, $urandom);
            apb_write(REG_STEADY, $urandom);
            apb_write(REG_BLINK_HALF, {16'($urandom), cur_half});
            apb_write(REG_BREATH_STEP, {16'($urandom), cur_step});
            if ($urandom_range(0, 9) == 0)
                apb_write($urandom_range(0, 1) ? SPARE_INDEX_LO : SPARE_INDEX_HI, $urandom);
        end
        apb_write(REG_EFFECT_MODE, {30'($urandom), mode});
        if (cur_half > 300 || cur_step > 300)
            n_ticks = $urandom_range(10, 30);
        else
            n_ticks = $urandom_range(20, 80);
    endtask

    // led receiver: random stalls, calm stretches, and the long hold-off on request
    initial
    begin
        int  stall;
        int  calm_left;
        bit  calm;
        stall     = 0;
        calm_left = 0;
        calm      = 1'b0;
        led_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 300);
            end
            calm_left--;
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = HOLD_OFF_CYCLES;
            end
            if (stall > 0)
            begin
                stall--;
                led_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < 20)
            begin
                stall = idle_len() - 1;
                led_ch.ready <= 1'b0;
            end
            else
                led_ch.ready <= 1'b1;
        end
    end

    // hang detector: any beat on tick, led or the register port resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (led_ch.valid && led_ch.ready)
            || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int n_ticks;
        bit keep_state;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        tick_ch.valid   <= 1'b0;
        tick_ch.restart <= 1'b0;
        rst_n           <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // off mode out of reset: ticks, restart included, make no color
        send_tick(1'b0);
        send_tick(1'b1);
        quiesce();

        // steady: armed since reset, shows once, then silent
        apb_write(REG_STEADY, 32'h00FF_FFFF);
        apb_write(REG_EFFECT_MODE, 32'(MODE_STEADY));
        send_tick(1'b0);
        send_tick(1'b0);
        quiesce();

        // rewriting the steady color does not re-arm it, a restart does
        apb_write(REG_STEADY, 32'h0000_0000);
        send_tick(1'b0);
        send_tick(1'b1);
        quiesce();

        // blink with the shortest half period: a, b, a
        apb_write(REG_COLOR_A, 32'h00FF_FFFF);
        apb_write(REG_COLOR_B, 32'h0000_0000);
        apb_write(REG_BLINK_HALF, 32'd1);
        apb_write(REG_EFFECT_MODE, 32'(MODE_BLINK));
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        quiesce();

        // a zero half period behaves as one
        apb_write(REG_BLINK_HALF, 32'd0);
        send_tick(1'b0);
        send_tick(1'b0);
        quiesce();

        // longest half period: one color, then quiet until restart
        apb_write(REG_BLINK_HALF, 32'h0000_FFFF);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        quiesce();

        // breath every tick on an uneven color to catch truncation
        apb_write(REG_COLOR_A, 32'h00FF_8001);
        apb_write(REG_BREATH_STEP, 32'd1);
        apb_write(REG_EFFECT_MODE, 32'(MODE_BREATH));
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        quiesce();

        // longest breath step
        apb_write(REG_BREATH_STEP, 32'h0000_FFFF);
        send_tick(1'b0);
        send_tick(1'b0);
        quiesce();

        // writes past the register map are ignored; mode switch keeps the running state
        apb_write(SPARE_INDEX_LO, 32'hFFFF_FFFF);
        apb_write(SPARE_INDEX_HI, 32'hFFFF_FFFF);
        apb_write(REG_EFFECT_MODE, 32'(MODE_BLINK));
        send_tick(1'b0);
        send_tick(1'b0);
        quiesce();

        // back-pressure: receiver holds off while ticks keep coming, then the sender
        // waits for every color before going on
        apb_write(REG_BLINK_HALF, 32'd1);
        cur_half = 16'd1;
        cur_step = 16'hFFFF;
        hold_req = 1'b1;
        tx_calm  = 1'b1;
        repeat (40) send_tick(1'b0);
        tx_calm = 1'b0;
        quiesce();

        // random phases, each with its own setting and sender mood
        while (ticks_sent < RANDOM_TICKS)
        begin
            shuffle_effect(n_ticks, keep_state);
            tx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
                hold_req = 1'b1;
            for (int i = 0; i < n_ticks; i++)
            begin
                if (i == 0 && !keep_state)
                    send_tick($urandom_range(0, 9) < 7);
                else
                    send_tick($urandom_range(0, 99) < 3);
                ticks_sent++;
            end
            quiesce();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
